FILE: sv/vn2d_pkg.sv
// Shared constants for the 2-D value noise pipeline.
// No dependencies; used by vn2d_hash, vn2d_weight and value_noise_2d.
package vn2d_pkg;

  // Coordinate format: signed 32-bit, FRAC_BITS fraction bits (8..24).
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned Q30_W      = 30;
  localparam int unsigned FRAC_PAD_W = Q30_W - FRAC_BITS;
  localparam int unsigned NOISE_W    = 31;

  // Pipeline depth, input register through output register.
  localparam int unsigned NUM_STAGES = 8;

  // Hash constants, all arithmetic modulo 2^32.
  localparam logic [31:0] HASH_MUL_Y  = 32'd57;
  localparam logic [31:0] HASH_MUL_S  = 32'd131;
  localparam int unsigned HASH_SHIFT  = 13;
  localparam logic [31:0] HASH_MUL_SQ = 32'd15731;
  localparam logic [31:0] HASH_ADD_SQ = 32'd789221;
  localparam logic [31:0] HASH_ADD_N  = 32'd1376312589;

  // Corner offsets on the hash seed value: x+1 adds 1, y+1 adds 57.
  localparam logic [31:0] OFS_X1   = 32'd1;
  localparam logic [31:0] OFS_Y1   = HASH_MUL_Y;
  localparam logic [31:0] OFS_X1Y1 = HASH_MUL_Y + 32'd1;

  // 3.0 in Q2.30, for the smoothstep linear term.
  localparam logic [31:0] THREE_Q30 = 32'hC000_0000;

endpackage

FILE: sv/vn2d_hash.sv
// Three-stage corner hash: n ^= n<<13, then the polynomial hash mapped to Q2.30.
// Depends on vn2d_pkg.
module vn2d_hash (
  input  logic               clk_i,
  input  logic [2:0]         en_i,
  input  logic [31:0]        n_i,
  output logic signed [30:0] g_o
);

  logic [31:0] nx;
  logic [31:0] nx_a_q, nx_a_d;
  logic [31:0] nsq_q, nsq_d;
  logic [31:0] nx_b_q;
  logic [31:0] inner_q, inner_d;
  logic [31:0] prod;
  logic [31:0] h;
  logic signed [30:0] g_q, g_d;

  assign nx     = n_i ^ (n_i << vn2d_pkg::HASH_SHIFT);
  assign nx_a_d = nx;
  assign nsq_d  = nx * nx;

  assign inner_d = nsq_q * vn2d_pkg::HASH_MUL_SQ + vn2d_pkg::HASH_ADD_SQ;

  assign prod = nx_b_q * inner_q;
  assign h    = prod + vn2d_pkg::HASH_ADD_N;
  // h[30:0] - 2^30 is just bit 30 inverted
  assign g_d  = $signed({~h[30], h[29:0]});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      nx_a_q <= nx_a_d;
      nsq_q  <= nsq_d;
    end
    if (en_i[1]) begin
      nx_b_q  <= nx_a_q;
      inner_q <= inner_d;
    end
    if (en_i[2]) begin
      g_q <= g_d;
    end
  end

  assign g_o = g_q;

endmodule

FILE: sv/vn2d_weight.sv
// Two-stage smoothstep weight w = t*t*(3-2t), all in Q0.30 / Q2.30.
// Depends on vn2d_pkg.
module vn2d_weight (
  input  logic        clk_i,
  input  logic [1:0]  en_i,
  input  logic [29:0] t_i,
  output logic [29:0] w_o
);

  logic [59:0] sq_full;
  logic [29:0] sq_q, sq_d;
  logic [29:0] t_q;
  logic [31:0] lin;
  logic [61:0] w_full;
  logic [29:0] w_q, w_d;

  assign sq_full = {30'd0, t_i} * {30'd0, t_i};
  assign sq_d    = sq_full[59:30];

  assign lin    = vn2d_pkg::THREE_Q30 - {1'b0, t_q, 1'b0};
  assign w_full = {32'd0, sq_q} * {30'd0, lin};
  // t < 1 keeps the weight below 1.0
  assign w_d    = w_full[59:30];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sq_q <= sq_d;
      t_q  <= t_i;
    end
    if (en_i[1]) begin
      w_q <= w_d;
    end
  end

  assign w_o = w_q;

endmodule

FILE: sv/vn2d_lerp.sv
// Two-stage linear blend g0 + (g1-g0)*w in Q2.30, truncated toward zero.
// Depends on no package or other module.
module vn2d_lerp (
  input  logic               clk_i,
  input  logic [1:0]         en_i,
  input  logic signed [30:0] g0_i,
  input  logic signed [30:0] g1_i,
  input  logic [29:0]        w_i,
  output logic signed [30:0] res_o
);

  logic signed [31:0] diff;
  logic signed [62:0] diff_ext;
  logic signed [62:0] w_ext;
  logic signed [62:0] prod_q, prod_d;
  logic signed [30:0] g0_q;
  logic signed [63:0] acc;
  logic               round_up;
  logic signed [30:0] res_q, res_d;

  assign diff     = 32'(g1_i) - 32'(g0_i);
  assign diff_ext = 63'(diff);
  assign w_ext    = $signed({33'd0, w_i});
  assign prod_d   = diff_ext * w_ext;

  // g0*(1-w) + g1*w == g0*2^30 + (g1-g0)*w
  assign acc      = $signed({{3{g0_q[30]}}, g0_q, 30'd0}) + 64'(prod_q);
  assign round_up = acc[63] && (|acc[29:0]);
  assign res_d    = $signed(acc[60:30] + {30'd0, round_up});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      g0_q   <= g0_i;
    end
    if (en_i[1]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: sv/value_noise_2d.sv
// 2-D value noise, Q16.16 point plus 32-bit seed in, Q2.30 sample out. The
// block is an eight-stage pipeline and takes one point in every cycle while
// the output is not stalled. Each stage has its own valid bit and advances
// when it is empty or the stage after it moves, so bubbles close up and a
// stall on the output holds every transaction in place. Stages: floor and
// seed mix, three hash stages (one 32x32 multiply each, four corners in
// parallel), two for the x blend, two for the y blend; the last blend
// register is the output register. Reset clears the valid bits.
// Depends on vn2d_pkg, vn2d_hash, vn2d_weight, vn2d_lerp.
module value_noise_2d (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic [31:0]        noise_seed_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [30:0] noise_value_o
);

  localparam int unsigned NS = vn2d_pkg::NUM_STAGES;

  logic [NS-1:0] valid_q, valid_d;
  logic [NS-1:0] en;

  logic [31:0] ix, iy;
  logic [31:0] n00_q, n00_d;
  logic [29:0] tx_q, tx_d, ty_q, ty_d;

  logic [31:0] n00, n10, n01, n11;
  logic signed [30:0] g00, g10, g01, g11;
  logic [29:0] wx, wy;
  logic [29:0] wx_s4_q;
  logic [29:0] wy_s4_q, wy_s5_q, wy_s6_q;
  logic signed [30:0] row0, row1;

  // Stall chain, output end first.
  always_comb begin
    logic nxt;
    nxt = out_ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !valid_q[i] || nxt;
      nxt   = en[i];
    end
  end

  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int i = 1; i < NS; i++) begin
      if (en[i]) begin
        valid_d[i] = valid_q[i-1];
      end else begin
        valid_d[i] = valid_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NS-1];

  // Stage 1: floor index (arithmetic shift) and corner-00 hash seed.
  assign ix    = 32'(coord_x_i >>> vn2d_pkg::FRAC_BITS);
  assign iy    = 32'(coord_y_i >>> vn2d_pkg::FRAC_BITS);
  assign n00_d = ix + iy * vn2d_pkg::HASH_MUL_Y + noise_seed_i * vn2d_pkg::HASH_MUL_S;
  assign tx_d  = {coord_x_i[vn2d_pkg::FRAC_BITS-1:0], {vn2d_pkg::FRAC_PAD_W{1'b0}}};
  assign ty_d  = {coord_y_i[vn2d_pkg::FRAC_BITS-1:0], {vn2d_pkg::FRAC_PAD_W{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      n00_q <= n00_d;
      tx_q  <= tx_d;
      ty_q  <= ty_d;
    end
  end

  // Neighbor corners differ from corner 00 by a constant, wrapping mod 2^32.
  assign n00 = n00_q;
  assign n10 = n00_q + vn2d_pkg::OFS_X1;
  assign n01 = n00_q + vn2d_pkg::OFS_Y1;
  assign n11 = n00_q + vn2d_pkg::OFS_X1Y1;

  vn2d_hash u_hash00 (.clk_i(clk_i), .en_i(en[3:1]), .n_i(n00), .g_o(g00));
  vn2d_hash u_hash10 (.clk_i(clk_i), .en_i(en[3:1]), .n_i(n10), .g_o(g10));
  vn2d_hash u_hash01 (.clk_i(clk_i), .en_i(en[3:1]), .n_i(n01), .g_o(g01));
  vn2d_hash u_hash11 (.clk_i(clk_i), .en_i(en[3:1]), .n_i(n11), .g_o(g11));

  vn2d_weight u_weight_x (.clk_i(clk_i), .en_i(en[2:1]), .t_i(tx_q), .w_o(wx));
  vn2d_weight u_weight_y (.clk_i(clk_i), .en_i(en[2:1]), .t_i(ty_q), .w_o(wy));

  // Weights are ready after stage 3; line them up with the blends.
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      wx_s4_q <= wx;
      wy_s4_q <= wy;
    end
    if (en[4]) begin
      wy_s5_q <= wy_s4_q;
    end
    if (en[5]) begin
      wy_s6_q <= wy_s5_q;
    end
  end

  vn2d_lerp u_lerp_row0 (
    .clk_i(clk_i), .en_i(en[5:4]), .g0_i(g00), .g1_i(g10), .w_i(wx_s4_q), .res_o(row0)
  );
  vn2d_lerp u_lerp_row1 (
    .clk_i(clk_i), .en_i(en[5:4]), .g0_i(g01), .g1_i(g11), .w_i(wx_s4_q), .res_o(row1)
  );
  vn2d_lerp u_lerp_col (
    .clk_i(clk_i), .en_i(en[7:6]), .g0_i(row0), .g1_i(row1), .w_i(wy_s6_q),
    .res_o(noise_value_o)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for value_noise_2d: bursty point stream in, stalling sink out,
// every noise sample checked against a local bit-exact lattice hash and smoothstep blend.
// Depends on vn2d_pkg and the value_noise_2d RTL.
module tb_top;

  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam int unsigned NUM_RANDOM = 1450;
  localparam int unsigned DRAIN_CYCLES = 4 * vn2d_pkg::NUM_STAGES;
  // Worst case scales with about 1500 points, the longest gap and the sparsest sink, well inside the watchdog.
  localparam int unsigned WATCHDOG_NS = 5_000_000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        seed;
  } point_t;

  typedef enum logic [1:0] {
    SINK_FLOW,
    SINK_COIN,
    SINK_MOSTLY,
    SINK_STARVED
  } sink_mode_e;

  logic               clk_i;
  logic               rst_n = 1'b0;
  logic               in_valid_q = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] coord_x_q = '0;
  logic signed [31:0] coord_y_q = '0;
  logic [31:0]        seed_q = '0;
  logic               out_valid_o;
  logic               out_ready_q = 1'b0;
  logic signed [30:0] noise_value_o;

  point_t     pending_points[$];
  logic [30:0] expected_noise[$];
  int unsigned err_cnt = 0;

  value_noise_2d u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid_q),
    .in_ready_o   (in_ready_o),
    .coord_x_i    (coord_x_q),
    .coord_y_i    (coord_y_q),
    .noise_seed_i (seed_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_q),
    .noise_value_o(noise_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Corner value in Q2.30: integer hash folded to 31 bits, then centered on zero.
  function automatic longint lattice_hash(logic [31:0] cx, logic [31:0] cy, logic [31:0] seed);
    logic [31:0] n;
    logic [31:0] sq;
    n  = cx + cy * 32'd57 + seed * 32'd131;
    n  = n ^ (n << 13);
    sq = n * n;
    sq = sq * 32'd15731 + 32'd789221;
    n  = n * sq + 32'd1376312589;
    return longint'(n[30:0]) - ONE_Q30;
  endfunction

  // Smoothstep weight in Q0.30, truncating after the square and after the product.
  function automatic longint ease_q30(logic [vn2d_pkg::FRAC_BITS-1:0] f);
    logic [63:0] t;
    logic [63:0] sq;
    logic [63:0] lin;
    t   = 64'(f) << (30 - vn2d_pkg::FRAC_BITS);
    sq  = (t * t) >> 30;
    lin = (64'd3 << 30) - 2 * t;
    return longint'((sq * lin) >> 30);
  endfunction

  function automatic longint lerp_q30(longint a, longint b, longint w);
    return (a * (ONE_Q30 - w) + b * w) / ONE_Q30;
  endfunction

  function automatic logic [30:0] noise_at(point_t p);
    logic [31:0] ix;
    logic [31:0] iy;
    longint      wx;
    longint      wy;
    longint      row0;
    longint      row1;
    longint      v;
    // floor, not truncation toward zero
    ix   = p.x >>> vn2d_pkg::FRAC_BITS;
    iy   = p.y >>> vn2d_pkg::FRAC_BITS;
    wx   = ease_q30(p.x[vn2d_pkg::FRAC_BITS-1:0]);
    wy   = ease_q30(p.y[vn2d_pkg::FRAC_BITS-1:0]);
    row0 = lerp_q30(lattice_hash(ix, iy, p.seed), lattice_hash(ix + 1, iy, p.seed), wx);
    row1 = lerp_q30(lattice_hash(ix, iy + 1, p.seed),
                    lattice_hash(ix + 1, iy + 1, p.seed), wx);
    v    = lerp_q30(row0, row1, wy);
    return v[30:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] seed);
    point_t p;
    p.x    = x;
    p.y    = y;
    p.seed = seed;
    pending_points.insert(pending_points.size(), p);
  endtask

  // Sender: bursts of random length separated by random gaps; gap of zero joins bursts.
  always @(posedge clk_i or negedge rst_n) begin : point_driver
    logic   fire;
    point_t p;
    int     burst_left;
    int     gap_left;
    if (!rst_n) begin
      in_valid_q <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      fire = in_valid_q && in_ready_o;
      if (fire) begin
        p.x    = coord_x_q;
        p.y    = coord_y_q;
        p.seed = seed_q;
        expected_noise.insert(expected_noise.size(), noise_at(p));
      end
      if (!in_valid_q || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_q <= 1'b0;
        end else if (pending_points.size() != 0) begin
          p = pending_points.pop_front();
          coord_x_q  <= p.x;
          coord_y_q  <= p.y;
          seed_q     <= p.seed;
          in_valid_q <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_q <= 1'b0;
        end
      end
    end
  end

  // Sink: switches at random between stall patterns, each held for a random stretch.
  always @(posedge clk_i or negedge rst_n) begin : sink_driver
    sink_mode_e mode;
    int         mode_left;
    if (!rst_n) begin
      out_ready_q <= 1'b0;
      mode      = SINK_FLOW;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      case (mode)
        SINK_FLOW:    out_ready_q <= 1'b1;
        SINK_COIN:    out_ready_q <= ($urandom_range(0, 1) == 1);
        SINK_MOSTLY:  out_ready_q <= ($urandom_range(0, 3) != 0);
        default:      out_ready_q <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : noise_monitor
    logic [30:0] want;
    if (rst_n && out_valid_o && out_ready_q) begin
      if (expected_noise.size() == 0) begin
        report_mismatch($sformatf("unexpected sample %h", noise_value_o));
      end else begin
        want = expected_noise.pop_front();
        if (noise_value_o !== want)
          report_mismatch($sformatf("noise_value got %h want %h", noise_value_o, want));
      end
    end
  end

  initial begin : stimulus
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] s;
    logic [31:0] fracs[5];
    fracs = '{32'h0000, 32'h0001, 32'h8000, 32'hfffe, 32'hffff};

    // Extremes, cell edges, negative floor correction and corner wrap at -1.
    push_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000);
    push_point(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
    push_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    push_point(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);
    push_point(32'h0000_ffff, 32'h0000_0001, 32'h1234_5678);
    push_point(32'h0001_0000, 32'hffff_0000, 32'h0000_0000);
    push_point(32'hfffe_8000, 32'h0000_8000, 32'hdead_beef);
    push_point(32'hffff_8000, 32'hffff_0001, 32'h0000_0001);
    push_point(32'h7fff_0000, 32'h8000_ffff, 32'h7fff_ffff);
    push_point(32'h0000_0001, 32'hffff_ffff, 32'h8000_0001);
    push_point(32'hffff_0000, 32'hffff_ffff, 32'h0000_0000);
    push_point(32'h0000_8000, 32'h0000_8000, 32'hffff_ffff);
    push_point(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    push_point(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
          x = $urandom();
          y = $urandom();
          s = $urandom();
        end
        10, 11, 12, 13, 14: begin
          // near the origin, both signs
          x = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
          y = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
          s = $urandom_range(0, 15);
        end
        15, 16, 17: begin
          x = {16'($urandom()), fracs[$urandom_range(0, 4)][15:0]};
          y = {16'($urandom()), fracs[$urandom_range(0, 4)][15:0]};
          s = $urandom();
        end
        default: begin
          x = $urandom();
          y = $urandom();
          s = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
        end
      endcase
      push_point(x, y, s);
    end

    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;

    while (pending_points.size() != 0 || in_valid_q) @(posedge clk_i);
    while (expected_noise.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0 && expected_noise.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("[%0t] ERROR: timeout, %0d samples outstanding", $time, expected_noise.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
sv/vn2d_pkg.sv
sv/vn2d_hash.sv
sv/vn2d_weight.sv
sv/vn2d_lerp.sv
sv/value_noise_2d.sv
tb/tb_top.sv
